// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every edge outside reset
`define TRFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define TRFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TRFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/trfs_pkg.sv =====
// ----------------------------------------------------------------------------
// trfs_pkg
// types and codes of the two-relay firing sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trfs_pkg;

  localparam int DUR_W = 16;

  // item kinds
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_START   = 2'd1;
  localparam logic [1:0] ACT_STOP    = 2'd2;
  localparam logic [1:0] ACT_INHIBIT = 2'd3;

  // sequence phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PREFIRE  = 3'd1;
  localparam logic [2:0] PH_SPINUP   = 3'd2;
  localparam logic [2:0] PH_FIRING   = 3'd3;
  localparam logic [2:0] PH_SPINDOWN = 3'd4;

  // register indexes
  localparam logic [2:0] REG_RELAY2_EN   = 3'd0;
  localparam logic [2:0] REG_DEFAULT_DUR = 3'd1;
  localparam logic [2:0] REG_MIN_DUR     = 3'd2;
  localparam logic [2:0] REG_MAX_DUR     = 3'd3;
  localparam logic [2:0] REG_PREFIRE_DLY = 3'd4;
  localparam logic [2:0] REG_SPIN_DLY    = 3'd5;

  typedef struct packed {
    logic             relay2_en;
    logic [DUR_W-1:0] default_dur;
    logic [DUR_W-1:0] min_dur;
    logic [DUR_W-1:0] max_dur;
    logic [DUR_W-1:0] prefire_dly;
    logic [DUR_W-1:0] spin_dly;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [DUR_W-1:0] req_dur;
    logic             immediate_spin;
    logic             inhibit_value;
  } item_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic [DUR_W-1:0] active_duration;
    logic             inhibit;
    logic             relay_one;
    logic             relay_two;
  } seq_state_t;

  // last member sits in bit 0
  typedef struct packed {
    logic       start_accepted;
    logic       is_inhibited;
    logic [2:0] phase;
    logic       relay_two_on;
    logic       relay_one_on;
  } result_t;

endpackage

// ===== rtl/trfs_step.sv =====
// ----------------------------------------------------------------------------
// trfs_step
// next-state and result logic for one item of the firing sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trfs_step
  import trfs_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  cfg_t                  cfg_i,
  input  seq_state_t            state_i,
  input  logic [TIME_WIDTH-1:0] elapsed_i,
  input  item_t                 item_i,
  output seq_state_t            state_o,
  output logic [TIME_WIDTH-1:0] elapsed_o,
  output result_t               result_o
);

  localparam int CW = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;
  localparam logic [TIME_WIDTH-1:0] CNT_MAX = {TIME_WIDTH{1'b1}};

  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [DUR_W-1:0]      dur_pick;
  logic [DUR_W-1:0]      dur_clamped;
  logic                  rch_prefire;
  logic                  rch_spin;
  logic                  rch_active;
  logic                  stop_to_spindown;
  logic                  accepted;

  // a delay beyond the counter range counts as reached once the counter saturates
  function automatic logic reached(input logic [TIME_WIDTH-1:0] cnt,
                                   input logic [DUR_W-1:0] dly);
    reached = (cnt == CNT_MAX) || (CW'(cnt) >= CW'(dly));
  endfunction

  assign elapsed_inc = (elapsed_i == CNT_MAX) ? elapsed_i : elapsed_i + TIME_WIDTH'(1);
  assign rch_prefire = reached(elapsed_inc, cfg_i.prefire_dly);
  assign rch_spin    = reached(elapsed_inc, cfg_i.spin_dly);
  assign rch_active  = reached(elapsed_inc, state_i.active_duration);

  // min test first, so min wins over max
  assign dur_pick = (item_i.req_dur == '0) ? cfg_i.default_dur : item_i.req_dur;
  always_comb begin
    priority if (dur_pick < cfg_i.min_dur) begin
      dur_clamped = cfg_i.min_dur;
    end else if (dur_pick > cfg_i.max_dur) begin
      dur_clamped = cfg_i.max_dur;
    end else begin
      dur_clamped = dur_pick;
    end
  end

  assign stop_to_spindown = cfg_i.relay2_en &&
                            ((state_i.phase == PH_SPINUP) || (state_i.phase == PH_FIRING));

  always_comb begin
    state_o   = state_i;
    elapsed_o = elapsed_i;
    accepted  = 1'b0;
    unique case (item_i.action)
      ACT_TICK: begin
        if (state_i.phase != PH_IDLE) begin
          elapsed_o = elapsed_inc;
          unique case (state_i.phase)
            PH_PREFIRE: begin
              if (rch_prefire) begin
                state_o.relay_one = 1'b1;
                state_o.relay_two = 1'b0;
                state_o.phase     = PH_SPINUP;
                elapsed_o         = '0;
              end
            end
            PH_SPINUP: begin
              if (!cfg_i.relay2_en) begin
                if (rch_active) begin
                  state_o.relay_one = 1'b0;
                  state_o.relay_two = 1'b0;
                  state_o.phase     = PH_IDLE;
                end
              end else if (rch_spin) begin
                state_o.relay_two = 1'b1;
                state_o.phase     = PH_FIRING;
                elapsed_o         = '0;
              end
            end
            PH_FIRING: begin
              if (rch_active) begin
                state_o.relay_two = 1'b0;
                state_o.phase     = PH_SPINDOWN;
                elapsed_o         = '0;
              end
            end
            PH_SPINDOWN: begin
              if (rch_spin) begin
                state_o.relay_one = 1'b0;
                state_o.phase     = PH_IDLE;
              end
            end
            default: begin
              state_o.relay_one = 1'b0;
              state_o.relay_two = 1'b0;
              state_o.phase     = PH_IDLE;
            end
          endcase
        end
      end
      ACT_START: begin
        if (!state_i.inhibit && (state_i.phase == PH_IDLE)) begin
          state_o.active_duration = dur_clamped;
          elapsed_o               = '0;
          accepted                = 1'b1;
          if (item_i.immediate_spin) begin
            state_o.relay_one = 1'b1;
            state_o.relay_two = 1'b0;
            state_o.phase     = PH_SPINUP;
          end else begin
            state_o.phase = PH_PREFIRE;
          end
        end
      end
      ACT_STOP, ACT_INHIBIT: begin
        // raising inhibit behaves as a stop; lowering only clears the flag
        if ((item_i.action == ACT_STOP) ||
            (item_i.inhibit_value && !state_i.inhibit)) begin
          if (stop_to_spindown) begin
            state_o.relay_two = 1'b0;
            state_o.phase     = PH_SPINDOWN;
            elapsed_o         = '0;
          end else begin
            state_o.relay_one = 1'b0;
            state_o.relay_two = 1'b0;
            state_o.phase     = PH_IDLE;
          end
        end
        if (item_i.action == ACT_INHIBIT) begin
          state_o.inhibit = item_i.inhibit_value;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  always_comb begin
    result_o.relay_one_on   = state_o.relay_one;
    result_o.relay_two_on   = state_o.relay_two;
    result_o.phase          = state_o.phase;
    result_o.is_inhibited   = state_o.inhibit;
    result_o.start_accepted = accepted;
  end

endmodule

// ===== rtl/two_relay_fire_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// two_relay_fire_sequencer_top
// timed two-relay firing sequencer with tick, start, stop and inhibit words
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tuser: action; tdata: req_dur, immediate_spin, inhibit_value
//  out_    | master    | tdata: relay_one_on, relay_two_on, phase, is_inhibited,
//          |           |        start_accepted
//  cfg_    | write     | cfg_addr selects register, cfg_wdata 16 bits
//
//  one word per cycle sustained while out_tready stays high; a word lands in the
//  input register and, once the result register is free or being taken, updates the
//  sequence state and fills the result register, which drives out_tvalid
//  a result waiting on out_tready holds one further word in the input register
//  reset (synchronous, rst_n low) restores register defaults and the idle state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_relay_fire_sequencer_top
  import trfs_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // slave channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // req_dur[15:0], immediate_spin, inhibit_value
  input  logic [1:0]       in_tuser,   // action
  // master channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // relay_one_on, relay_two_on, phase[2:0],
                                       // is_inhibited, start_accepted
  // configuration
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [DUR_W-1:0] cfg_wdata
);

  cfg_t                  cfg_r;
  item_t                 in_item_r;
  logic                  in_v_r;
  result_t               out_data_r;
  logic                  out_v_r;
  seq_state_t            seq_r;
  seq_state_t            seq_nxt;
  logic [TIME_WIDTH-1:0] elapsed_r;
  logic [TIME_WIDTH-1:0] elapsed_nxt;
  result_t               result;
  logic                  fire;

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.relay2_en   <= 1'b1;
      cfg_r.default_dur <= DUR_W'(500);
      cfg_r.min_dur     <= DUR_W'(50);
      cfg_r.max_dur     <= DUR_W'(5000);
      cfg_r.prefire_dly <= '0;
      cfg_r.spin_dly    <= DUR_W'(200);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RELAY2_EN:   cfg_r.relay2_en   <= cfg_wdata[0];
        REG_DEFAULT_DUR: cfg_r.default_dur <= cfg_wdata;
        REG_MIN_DUR:     cfg_r.min_dur     <= cfg_wdata;
        REG_MAX_DUR:     cfg_r.max_dur     <= cfg_wdata;
        REG_PREFIRE_DLY: cfg_r.prefire_dly <= cfg_wdata;
        REG_SPIN_DLY:    cfg_r.spin_dly    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.action         <= in_tuser;
      in_item_r.req_dur        <= in_tdata[15:0];
      in_item_r.immediate_spin <= in_tdata[16];
      in_item_r.inhibit_value  <= in_tdata[17];
    end
  end

  trfs_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .cfg_i    (cfg_r),
    .state_i  (seq_r),
    .elapsed_i(elapsed_r),
    .item_i   (in_item_r),
    .state_o  (seq_nxt),
    .elapsed_o(elapsed_nxt),
    .result_o (result)
  );

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.phase           <= PH_IDLE;
      seq_r.active_duration <= '0;
      seq_r.inhibit         <= 1'b0;
      seq_r.relay_one       <= 1'b0;
      seq_r.relay_two       <= 1'b0;
      elapsed_r             <= '0;
    end else if (fire) begin
      seq_r     <= seq_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_data_r};

`include "assert_macros.svh"

  `TRFS_ASSERT_IMPL(a_relay_two_firing, seq_r.relay_two,
                    seq_r.relay_one && (seq_r.phase == PH_FIRING),
                    "relay two on outside firing or without relay one")
  `TRFS_ASSERT_IMPL(a_quiet_relays, (seq_r.phase == PH_IDLE) || (seq_r.phase == PH_PREFIRE),
                    !seq_r.relay_one && !seq_r.relay_two,
                    "relay energised while idle or in prefire")
  `TRFS_ASSERT_IMPL(a_start_from_idle, fire && result.start_accepted,
                    (seq_r.phase == PH_IDLE) && !seq_r.inhibit &&
                    (in_item_r.action == ACT_START),
                    "start accepted outside idle or while inhibited")
  `TRFS_ASSERT_NEXT(a_word_held, in_v_r && !fire, in_v_r && $stable(in_item_r),
                    "pending input word lost")

endmodule

// ===== test/two_relay_fire_sequencer_top_test.sv =====
// ----------------------------------------------------------------------------
// two_relay_fire_sequencer_top_test
// self-checking bench for the two-relay firing sequencer: words are queued,
// driven under random and held-off flow control, and every result word is
// checked field by field against an in-bench model of the phase sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_relay_fire_sequencer_top_test
  import trfs_pkg::*;
();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // req_dur[15:0], immediate_spin, inhibit_value
  logic [1:0]  in_tuser = '0;   // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // relay_one_on, relay_two_on, phase[2:0],
                                // is_inhibited, start_accepted
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  two_relay_fire_sequencer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // model of the sequencer
  cfg_t fire_cfg = '{relay2_en: 1'b1, default_dur: 16'd500, min_dur: 16'd50,
                     max_dur: 16'd5000, prefire_dly: 16'd0, spin_dly: 16'd200};
  logic [2:0]  seq_phase   = PH_IDLE;
  logic [15:0] seq_elapsed = '0;
  logic [15:0] seq_active  = '0;
  logic        seq_inhibit = 1'b0;
  logic        relay_one   = 1'b0;
  logic        relay_two   = 1'b0;

  item_t       pending_words[$];
  result_t     relay_outcomes[$];
  item_t       on_offer;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;
  int unsigned mismatches   = 0;

  function automatic void enter_phase(input logic [2:0] ph);
    seq_phase   = ph;
    seq_elapsed = '0;
  endfunction

  function automatic void stop_sequence();
    if (fire_cfg.relay2_en && (seq_phase == PH_SPINUP || seq_phase == PH_FIRING)) begin
      relay_two = 1'b0;
      enter_phase(PH_SPINDOWN);
    end else begin
      relay_one = 1'b0;
      relay_two = 1'b0;
      seq_phase = PH_IDLE;
    end
  endfunction

  function automatic result_t advance_sequencer(input item_t it);
    result_t     r;
    logic        took;
    logic [15:0] dur;
    took = 1'b0;
    case (it.action)
      ACT_TICK: begin
        if (seq_phase != PH_IDLE) begin
          // elapsed count saturates at the top of its range
          if (seq_elapsed != 16'hFFFF) seq_elapsed = seq_elapsed + 16'd1;
          case (seq_phase)
            PH_PREFIRE: begin
              if (seq_elapsed >= fire_cfg.prefire_dly) begin
                relay_one = 1'b1;
                relay_two = 1'b0;
                enter_phase(PH_SPINUP);
              end
            end
            PH_SPINUP: begin
              if (!fire_cfg.relay2_en) begin
                // single relay: spin-up is the firing time
                if (seq_elapsed >= seq_active) begin
                  relay_one = 1'b0;
                  relay_two = 1'b0;
                  seq_phase = PH_IDLE;
                end
              end else if (seq_elapsed >= fire_cfg.spin_dly) begin
                relay_two = 1'b1;
                enter_phase(PH_FIRING);
              end
            end
            PH_FIRING: begin
              if (seq_elapsed >= seq_active) begin
                relay_two = 1'b0;
                enter_phase(PH_SPINDOWN);
              end
            end
            PH_SPINDOWN: begin
              if (seq_elapsed >= fire_cfg.spin_dly) begin
                relay_one = 1'b0;
                seq_phase = PH_IDLE;
              end
            end
            default: begin
              relay_one = 1'b0;
              relay_two = 1'b0;
              seq_phase = PH_IDLE;
            end
          endcase
        end
      end
      ACT_START: begin
        if (!seq_inhibit && seq_phase == PH_IDLE) begin
          // zero means default, then minimum wins over maximum
          dur = it.req_dur;
          if (dur == 16'd0) dur = fire_cfg.default_dur;
          if (dur < fire_cfg.min_dur) dur = fire_cfg.min_dur;
          else if (dur > fire_cfg.max_dur) dur = fire_cfg.max_dur;
          seq_active = dur;
          if (it.immediate_spin) begin
            relay_one = 1'b1;
            relay_two = 1'b0;
            enter_phase(PH_SPINUP);
          end else begin
            enter_phase(PH_PREFIRE);
          end
          took = 1'b1;
        end
      end
      ACT_STOP: stop_sequence();
      default: begin
        if (it.inhibit_value != seq_inhibit) begin
          seq_inhibit = it.inhibit_value;
          if (seq_inhibit) stop_sequence();
        end
      end
    endcase
    r.relay_one_on   = relay_one;
    r.relay_two_on   = relay_two;
    r.phase          = seq_phase;
    r.is_inhibited   = seq_inhibit;
    r.start_accepted = took;
    return r;
  endfunction

  // sender: one word on offer, replaced only once taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) relay_outcomes.push_back(advance_sequencer(on_offer));
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          on_offer = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, on_offer.inhibit_value, on_offer.immediate_spin,
                        on_offer.req_dur};
          in_tuser  <= on_offer.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || rx_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t ns: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[6:0];
      if (relay_outcomes.size() == 0) begin
        flag_mismatch("unexpected result word", int'(out_tdata), 0);
      end else begin
        want = relay_outcomes.pop_front();
        if (seen.relay_one_on !== want.relay_one_on)
          flag_mismatch("relay_one_on", int'(seen.relay_one_on), int'(want.relay_one_on));
        if (seen.relay_two_on !== want.relay_two_on)
          flag_mismatch("relay_two_on", int'(seen.relay_two_on), int'(want.relay_two_on));
        if (seen.phase !== want.phase)
          flag_mismatch("phase", int'(seen.phase), int'(want.phase));
        if (seen.is_inhibited !== want.is_inhibited)
          flag_mismatch("is_inhibited", int'(seen.is_inhibited), int'(want.is_inhibited));
        if (seen.start_accepted !== want.start_accepted)
          flag_mismatch("start_accepted", int'(seen.start_accepted),
                        int'(want.start_accepted));
      end
    end
  end

  task automatic push_word(input logic [1:0] act, input logic [15:0] dur,
                           input logic imm, input logic inh);
    item_t it;
    it.action         = act;
    it.req_dur        = dur;
    it.immediate_spin = imm;
    it.inhibit_value  = inh;
    pending_words.push_back(it);
  endtask

  task automatic push_tick();
    push_word(ACT_TICK, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RELAY2_EN:   fire_cfg.relay2_en   = val[0];
      REG_DEFAULT_DUR: fire_cfg.default_dur = val;
      REG_MIN_DUR:     fire_cfg.min_dur     = val;
      REG_MAX_DUR:     fire_cfg.max_dur     = val;
      REG_PREFIRE_DLY: fire_cfg.prefire_dly = val;
      REG_SPIN_DLY:    fire_cfg.spin_dly    = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(REG_RELAY2_EN, {15'b0, c.relay2_en});
    write_reg(REG_DEFAULT_DUR, c.default_dur);
    write_reg(REG_MIN_DUR, c.min_dur);
    write_reg(REG_MAX_DUR, c.max_dur);
    write_reg(REG_PREFIRE_DLY, c.prefire_dly);
    write_reg(REG_SPIN_DLY, c.spin_dly);
  endtask

  // wait until nothing is queued, on offer or owed, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    while (pending_words.size() != 0 || relay_outcomes.size() != 0 || in_tvalid)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
      default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
    endcase
  endtask

  function automatic cfg_t pick_cfg(input int unsigned kind);
    cfg_t c;
    c.relay2_en   = 1'($urandom_range(1));
    c.default_dur = 16'($urandom_range(15));
    c.min_dur     = 16'($urandom_range(6));
    c.max_dur     = 16'($urandom_range(20));
    c.prefire_dly = 16'($urandom_range(6));
    c.spin_dly    = 16'($urandom_range(6));
    case (kind)
      1: c = '{relay2_en: 1'b1, default: '0};
      2: begin
        // minimum above maximum
        c.relay2_en = 1'b1;
        c.min_dur   = 16'($urandom_range(15, 9));
        c.max_dur   = 16'($urandom_range(5, 1));
      end
      3: begin
        c.default_dur = 16'hFFFF;
        c.min_dur     = 16'hFFFF;
        c.max_dur     = 16'hFFFF;
        c.prefire_dly = 16'hFFFF;
        c.spin_dly    = 16'hFFFF;
      end
      4: c.relay2_en = 1'b0;
      5: c = '{relay2_en: 1'b1, default_dur: 16'd500, min_dur: 16'd50,
               max_dur: 16'd5000, prefire_dly: 16'd0, spin_dly: 16'd200};
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_duration();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 16'd0;
    if (r < 70) return 16'($urandom_range(30, 1));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // mostly start-then-ticks runs sized to the current delays, the rest noise
  task automatic queue_burst(input int unsigned n);
    int unsigned made;
    int unsigned span;
    int unsigned k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 75) begin
        if ($urandom_range(1)) push_word(ACT_INHIBIT, 16'($urandom_range(16'hFFFF)),
                                         1'($urandom_range(1)), 1'b0);
        push_word(ACT_START, pick_duration(), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        span = int'(fire_cfg.prefire_dly) + 2 * int'(fire_cfg.spin_dly)
             + int'(fire_cfg.max_dur) + 4;
        if (span > 80) span = 80;
        k = $urandom_range(span);
        for (int unsigned i = 0; i < k; i++) begin
          if ($urandom_range(99) < 6)
            push_word(2'($urandom_range(3, 1)), pick_duration(), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
          else
            push_tick();
        end
        made += k + 1;
      end else begin
        push_word(2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                  1'($urandom_range(1)), ($urandom_range(2) == 0));
        made++;
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk through the phases and the refusal and inhibit cases
    c = '{relay2_en: 1'b1, default_dur: 16'd3, min_dur: 16'd2, max_dur: 16'd4,
          prefire_dly: 16'd2, spin_dly: 16'd1};
    program_regs(c);
    @(negedge clk);
    push_word(ACT_START, 16'd0, 1'b0, 1'b0);       // default duration, prefire
    push_word(ACT_START, 16'd5, 1'b1, 1'b0);       // refused while busy
    push_tick();
    push_tick();                                   // into spin-up
    push_tick();                                   // into firing
    push_word(ACT_STOP, 16'd0, 1'b0, 1'b0);        // firing to spin-down
    push_word(ACT_INHIBIT, 16'd0, 1'b0, 1'b1);     // inhibit in spin-down: all off
    push_word(ACT_INHIBIT, 16'hFFFF, 1'b1, 1'b1);  // same level, no change
    push_word(ACT_START, 16'd3, 1'b1, 1'b0);       // refused while inhibited
    push_tick();                                   // tick while idle
    push_word(ACT_INHIBIT, 16'd0, 1'b0, 1'b0);     // lowering only clears the flag
    push_word(ACT_STOP, 16'hFFFF, 1'b1, 1'b1);     // stop while idle
    push_word(ACT_START, 16'd1, 1'b1, 1'b0);       // below minimum, immediate spin
    push_word(ACT_INHIBIT, 16'd0, 1'b0, 1'b1);     // inhibit in spin-up
    push_word(ACT_INHIBIT, 16'd0, 1'b0, 1'b0);
    push_tick();                                   // spin-down ends
    push_word(ACT_START, 16'hFFFF, 1'b1, 1'b0);    // above maximum
    push_tick();                                   // into firing
    drain();
    // relay two switched off mid-fire: firing still ends in spin-down
    write_reg(REG_RELAY2_EN, 16'd0);
    @(negedge clk);
    repeat (5) push_tick();
    push_word(ACT_STOP, 16'd0, 1'b0, 1'b0);
    drain();

    for (int unsigned p = 0; p < 12; p++) begin
      c = pick_cfg(p < 6 ? p : $urandom_range(5));
      program_regs(c);
      @(negedge clk);
      set_idling(p % 4);
      if (p == 2) begin
        // long hold-off on the result side while words keep coming
        fork
          begin
            rx_hold = 1'b1;
            repeat (300) @(negedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      queue_burst(140);
      drain();
    end

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
